@@ hdl/one_wire_pulse_fault_monitor_unit_macros.svh @@
// assertion macros for the one-wire pulse fault monitor
`ifndef ONE_WIRE_PULSE_FAULT_MONITOR_UNIT_MACROS_SVH
`define ONE_WIRE_PULSE_FAULT_MONITOR_UNIT_MACROS_SVH

// checked on every clock edge outside reset
`define OWPFM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define OWPFM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/owpfm_pkg.sv @@
// types and constants of the one-wire pulse fault monitor
package owpfm_pkg;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 10;

    localparam logic [CFG_INDEX_W-1:0] CFG_BUS_MODE        = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOW_FAULT_LIMIT = 1'b1;

    localparam logic [8:0] RUN_SHORT_MAX = 9'd3;
    localparam logic [8:0] HIGH_RUN_CAP  = 9'd300;
    localparam logic [4:0] ERROR_LIMIT   = 5'd20;

    localparam logic       BUS_MODE_RESET        = 1'b1;
    localparam logic [9:0] LOW_FAULT_LIMIT_RESET = 10'd50;

    typedef struct packed {
        logic enable;
        logic power_ok;
        logic line_level;
    } owpfm_in_t;

    typedef struct packed {
        logic drive_low;
        logic stall_fault;
        logic running;
    } owpfm_out_t;

    typedef struct packed {
        logic       bus_mode;
        logic [9:0] low_fault_limit;
    } owpfm_cfg_t;

    typedef struct packed {
        logic       sample_phase;
        logic [9:0] low_run;
        logic [8:0] high_run;
        logic [4:0] short_pulse_errors;
        logic       fault_latch;
    } owpfm_state_t;

endpackage

@@ hdl/owpfm_judge.sv @@
// next-state and result logic for one word of the monitor
module owpfm_judge
    import owpfm_pkg::*;
(
    input  owpfm_state_t cur,
    input  owpfm_cfg_t   cfg,
    input  owpfm_in_t    in_word,
    output owpfm_state_t nxt,
    output owpfm_out_t   res
);

    logic        active;
    logic        drive;
    logic [10:0] low_inc;
    logic [5:0]  err_inc;

    assign active  = in_word.enable && in_word.power_ok && !cur.fault_latch;
    assign low_inc = {1'b0, cur.low_run} + 11'd1;
    assign err_inc = {1'b0, cur.short_pulse_errors} + 6'd1;

    always_comb
    begin
        nxt   = cur;
        drive = 1'b0;
        if (active)
        begin
            if (!cur.sample_phase)
            begin
                drive            = 1'b1;
                nxt.sample_phase = 1'b1;
            end
            else
            begin
                nxt.sample_phase = 1'b0;
                if (!cfg.bus_mode)
                begin
                    // consecutive low count
                    if (!in_word.line_level)
                    begin
                        if (low_inc > {1'b0, cfg.low_fault_limit})
                        begin
                            nxt.fault_latch = 1'b1;
                            nxt.low_run     = cfg.low_fault_limit;
                        end
                        else
                        begin
                            nxt.low_run = low_inc[9:0];
                        end
                    end
                    else
                    begin
                        nxt.low_run = '0;
                    end
                end
                else
                begin
                    // high run classification
                    if (!in_word.line_level)
                    begin
                        if (cur.high_run != '0)
                        begin
                            if (cur.high_run > RUN_SHORT_MAX)
                            begin
                                nxt.short_pulse_errors = '0;
                            end
                            else if (cur.high_run > 9'd1)
                            begin
                                if (err_inc > {1'b0, ERROR_LIMIT})
                                begin
                                    nxt.fault_latch        = 1'b1;
                                    nxt.short_pulse_errors = ERROR_LIMIT;
                                end
                                else
                                begin
                                    nxt.short_pulse_errors = err_inc[4:0];
                                end
                            end
                            else
                            begin
                                nxt.short_pulse_errors = '0;
                            end
                        end
                        nxt.high_run = '0;
                    end
                    else if (cur.high_run < HIGH_RUN_CAP)
                    begin
                        nxt.high_run = cur.high_run + 9'd1;
                    end
                    else
                    begin
                        nxt.high_run = HIGH_RUN_CAP;
                    end
                end
            end
        end
        else
        begin
            nxt.low_run            = '0;
            nxt.high_run           = '0;
            nxt.short_pulse_errors = '0;
        end
    end

    assign res.drive_low   = drive;
    assign res.stall_fault = nxt.fault_latch;
    assign res.running     = active;

endmodule

@@ hdl/one_wire_pulse_fault_monitor_unit.sv @@
// one-wire pulse fault monitor: one tick word in, one status word out, one word per cycle;
// the tick is judged combinationally against the phase, run counters and fault latch,
// and its status word sits in an output register; a new word is taken in every cycle in
// which that register is empty or being read, so the result appears in the cycle after
// acceptance and a stalled output holds back the input only while the register is full
`include "one_wire_pulse_fault_monitor_unit_macros.svh"

module one_wire_pulse_fault_monitor_unit
    import owpfm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  owpfm_in_t              in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output owpfm_out_t             out_data
);

    owpfm_state_t state_reg;
    owpfm_state_t state_next;
    owpfm_cfg_t   cfg_reg;
    owpfm_out_t   out_reg;
    owpfm_out_t   out_next;
    logic         out_valid_reg;
    logic         accept;

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    owpfm_judge u_judge (
        .cur     (state_reg),
        .cfg     (cfg_reg),
        .in_word (in_data),
        .nxt     (state_next),
        .res     (out_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bus_mode        <= BUS_MODE_RESET;
            cfg_reg.low_fault_limit <= LOW_FAULT_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BUS_MODE:        cfg_reg.bus_mode        <= cfg_wdata[0];
                CFG_LOW_FAULT_LIMIT: cfg_reg.low_fault_limit <= cfg_wdata[9:0];
                default:             cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_reg <= out_next;
        end
    end

    `OWPFM_ASSERT(a_fault_sticky, state_reg.fault_latch |=> state_reg.fault_latch, "fault latch cleared")
    `OWPFM_ASSERT_ALWAYS(a_counter_range, !rst_n || ((state_reg.high_run <= HIGH_RUN_CAP) && (state_reg.short_pulse_errors <= ERROR_LIMIT)), "run or error counter out of range")
    `OWPFM_ASSERT(a_drive_when_running, out_valid_reg |-> (!out_reg.drive_low || out_reg.running), "line driven while not running")
    `OWPFM_ASSERT(a_fault_reported, (out_valid_reg && out_reg.stall_fault) |-> state_reg.fault_latch, "fault reported without latch")

endmodule
